// File: sv/skt_pkg.sv
// Package for the sorted key table: sizes, opcode and status codes, FSM states
// and the key normalization function. No dependencies.
`default_nettype none

package skt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_CHARS   = 8;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 31;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_FOUND     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_PROBE,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

   // Keep the top KEY_CHARS bytes up to the first zero byte; clear the rest.
   function automatic logic [KEY_W-1:0] normalize_key(logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] res;
      logic             live;
      res  = '0;
      live = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i >= KEY_CHARS || raw[KEY_W-1-8*i -: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            res[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/sorted_key_table.sv
// Sorted key table: ordered key/value memories, binary search and shift engine.
// Depends on skt_pkg.
//
// Usage: raise start with req_opcode, req_key and req_value; the transaction
// is taken at the clock edge where start is high and busy is low. busy stays
// high until the reply. Each transaction gives exactly one reply, shown for a
// single cycle with rsp_valid high; the receiver cannot stall it, so capture
// it in that cycle. busy drops in the reply cycle, so the next transaction
// may be issued then.
// Sequence: each binary search step reads the memory, then compares; the
// probe and the decision follow. Lookup, duplicate, full and not-found replies
// come right after. Insert and remove then move the tail one entry at a time
// (read, then write back through the single memory port pair) before the reply.
// Reset: clears the entry count, the controller and rsp_valid. The memories
// are not cleared; only slots below the entry count are ever read.
// Reads and writes never target the same slot in one cycle, so no forwarding.
`default_nettype none

module sorted_key_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [skt_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [skt_pkg::KEY_W-1:0]     req_key,
   input  logic [skt_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [skt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [skt_pkg::POS_W-1:0]     rsp_position,
   output logic [skt_pkg::VALUE_W-1:0]   rsp_stored_value,
   output logic [skt_pkg::POS_W-1:0]     rsp_entry_total
);

   import skt_pkg::*;

   // Memories
   logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] val_mem [TABLE_DEPTH];

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_val_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [VALUE_W-1:0] wr_val;

   // Control and working registers
   state_type          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               hit_ff, hit_in;
   logic [VALUE_W-1:0] sval_ff, sval_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [VALUE_W-1:0] rsp_sval_ff, rsp_sval_in;
   logic [POS_W-1:0]   rsp_total_ff, rsp_total_in;

   // Shared conditions
   logic [CNT_W-1:0]   mid;
   logic [CNT_W-1:0]   idx_next_up;
   logic               search_more;
   logic               probe_needed;
   logic               table_full;
   logic               is_insert;
   logic               is_remove;
   logic               shift_more;

   assign mid          = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_next_up  = idx_ff + CNT_W'(1);
   assign search_more  = lo_ff < hi_ff;
   assign probe_needed = lo_ff < count_ff;
   assign table_full   = count_ff >= CNT_W'(TABLE_DEPTH);
   assign is_insert    = op_ff == OP_INSERT;
   assign is_remove    = op_ff == OP_REMOVE;
   assign shift_more   = is_insert ? (idx_ff > lo_ff) : (idx_next_up < count_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (search_more) begin
               state_in = S_COMPARE;
            end else if (probe_needed) begin
               state_in = S_PROBE;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_COMPARE: state_in = S_SEARCH;
         S_PROBE:   state_in = S_DECIDE;
         S_DECIDE: begin
            priority if (is_insert) begin
               state_in = (hit_ff || table_full) ? S_IDLE : S_SHIFT_RD;
            end else if (is_remove) begin
               state_in = hit_ff ? S_SHIFT_RD : S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT_RD: state_in = shift_more ? S_SHIFT_WR : S_IDLE;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      sval_in       = sval_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_sval_in   = rsp_sval_ff;
      rsp_total_in  = rsp_total_ff;
      rd_en         = 1'b0;
      rd_addr       = mid[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_key        = rd_key_ff;
      wr_val        = rd_val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               key_in   = normalize_key(req_key);
               value_in = req_value;
               lo_in    = '0;
               hi_in    = count_ff;
            end
         end
         S_SEARCH: begin
            priority if (search_more) begin
               rd_en   = 1'b1;
               rd_addr = mid[IDX_W-1:0];
            end else if (probe_needed) begin
               rd_en   = 1'b1;
               rd_addr = lo_ff[IDX_W-1:0];
            end else begin
               hit_in = 1'b0;
            end
         end
         S_COMPARE: begin
            if (rd_key_ff < key_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         S_PROBE: begin
            hit_in  = rd_key_ff == key_ff;
            sval_in = rd_val_ff;
         end
         S_DECIDE: begin
            rsp_pos_in   = POS_W'(lo_ff);
            rsp_sval_in  = '0;
            rsp_total_in = POS_W'(count_ff);
            idx_in       = is_insert ? count_ff : lo_ff;
            priority if (is_insert) begin
               priority if (hit_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_DUPLICATE;
               end else if (table_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_INSERTED;
               end
            end else if (is_remove) begin
               if (!hit_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOTFOUND;
               end
            end else begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_status_in = ST_FOUND;
                  rsp_sval_in   = sval_ff;
               end else begin
                  rsp_status_in = ST_NOTFOUND;
               end
            end
         end
         S_SHIFT_RD: begin
            if (shift_more) begin
               rd_en   = 1'b1;
               rd_addr = is_insert ? IDX_W'(idx_ff - CNT_W'(1)) : idx_next_up[IDX_W-1:0];
            end else if (is_insert) begin
               // Tail moved up: drop the new entry into the gap
               wr_en         = 1'b1;
               wr_addr       = lo_ff[IDX_W-1:0];
               wr_key        = key_ff;
               wr_val        = value_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_pos_in    = POS_W'(lo_ff);
               rsp_sval_in   = '0;
               rsp_total_in  = POS_W'(count_in);
            end else begin
               count_in      = count_ff - CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_REMOVED;
               rsp_pos_in    = POS_W'(lo_ff);
               rsp_sval_in   = '0;
               rsp_total_in  = POS_W'(count_in);
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            idx_in  = is_insert ? (idx_ff - CNT_W'(1)) : idx_next_up;
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      sval_ff       <= sval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_sval_ff   <= rsp_sval_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign busy             = reset || (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_stored_value = rsp_sval_ff;
   assign rsp_entry_total  = rsp_total_ff;

   // Checks
   a_single_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("reply strobe held for more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but block not busy");

   a_insert_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_INSERTED) |-> rsp_entry_total != '0)
      else $error("insert reported with an empty table");

endmodule

`default_nettype wire
